>>> hw/rtl/ofc_pkg.sv
// ----------------------------------------------------------------------------
// ofc_pkg
// Shared types and constants for the overlapping frame chunker.
// ----------------------------------------------------------------------------
`default_nettype none

package ofc_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int MAX_DIM_DEF    = 128;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 8;

    localparam int SS_W = 4;
    localparam int DC_W = 5;
    localparam int RL_W = 7;
    localparam int FD_W = 8;

    // Chunk size, stride and most counter comparisons are carried out at this width.
    localparam int SIZE_W = 10;

    localparam logic [SS_W-1:0] SS_RESET = SS_W'(4);
    localparam logic [DC_W-1:0] DC_RESET = DC_W'(1);
    localparam logic [RL_W-1:0] RL_RESET = RL_W'(7);
    localparam logic            ZF_RESET = 1'b0;
    localparam logic [FD_W-1:0] FD_RESET = FD_W'(80);

    localparam logic [SIZE_W-1:0] SS_MAX = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] DC_MAX = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] RL_MAX = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] FD_MAX = SIZE_W'(128);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_EOS   = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_FULL      = 3'd2,
        ST_BUSY      = 3'd3,
        ST_CFG_ERR   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUBSAMPLING = 3'd0,
        CFG_DEC_CHUNK   = 3'd1,
        CFG_RECEPTIVE   = 3'd2,
        CFG_ZERO_FILL   = 3'd3,
        CFG_FRAME_DIM   = 3'd4
    } t_cfg_index;

endpackage

`default_nettype wire

>>> hw/rtl/ofc_ram.sv
// ----------------------------------------------------------------------------
// ofc_ram
// Generic simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/overlapping_frame_chunker.sv
// ----------------------------------------------------------------------------
// overlapping_frame_chunker
// Collects feature frames a word at a time and hands them out as overlapping
// chunks, one word per pull transaction.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the input stream while
// the output side is not stalled, and returns exactly one result transaction
// for each, through the first stage and the output register. Pushes write one
// word of the frame store and pulls read one word of it or, when padding,
// write a zero word, so the single port of each kind on the frame store sets
// the rate of one word per cycle. The frame store holds MAX_FRAMES frames of
// MAX_DIM words and needs no clearing pass after reset, so the block is ready
// for traffic in the first cycle after reset. Configuration writes take effect
// at once and are meant to arrive while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module overlapping_frame_chunker
    import ofc_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [WORD_W-1:0]    i_s_axis_tdata,  // [31:0] word_in
    input  wire logic [OP_W-1:0]      i_s_axis_tuser,  // [1:0] opcode
    // Output stream.
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [WORD_W-1:0]    o_m_axis_tdata,  // [31:0] word_out
    output logic                      o_m_axis_tlast,  // chunk_last
    output logic      [STATUS_W:0]    o_m_axis_tuser   // [0] word_valid, [3:1] status
);

    localparam int DEPTH  = MAX_FRAMES * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HF_W   = $clog2(MAX_FRAMES);
    localparam int FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int WD_W   = $clog2(MAX_DIM + 1);
    localparam logic [SIZE_W-1:0] MAX_FRAMES_C = SIZE_W'(MAX_FRAMES);
    localparam logic [SIZE_W-1:0] MAX_DIM_C    = SIZE_W'(MAX_DIM);
    localparam logic [ADDR_W-1:0] DIM_ADDR     = ADDR_W'(MAX_DIM);

    // Configuration registers.
    logic [SS_W-1:0] r_ss;
    logic [DC_W-1:0] r_dc;
    logic [RL_W-1:0] r_rl;
    logic            r_zf;
    logic [FD_W-1:0] r_fd;

    // Chunker state.
    logic [HF_W-1:0] r_head,    n_head;
    logic [FC_W-1:0] r_fh,      n_fh;
    logic [WD_W-1:0] r_wwi,     n_wwi;
    logic [FC_W-1:0] r_efc,     n_efc;
    logic [WD_W-1:0] r_ewi,     n_ewi;
    logic [FC_W-1:0] r_ccf,     n_ccf;
    logic            r_ended,   n_ended;
    logic            r_emitting, n_emitting;

    // First stage, aligned with the frame store read data.
    logic            r_a_valid;
    logic            r_a_wvalid, n_a_wvalid;
    logic            r_a_pad,    n_a_pad;
    logic            r_a_last,   n_a_last;
    t_status         r_a_status, n_a_status;

    // Output register.
    logic                r_o_valid;
    logic [WORD_W-1:0]   r_o_word;
    logic                r_o_wvalid;
    logic                r_o_last;
    t_status             r_o_status;

    logic              accept;
    logic              a_move;
    t_opcode           op;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] stride;
    logic [SIZE_W-1:0] keep;
    logic              cfg_bad;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] ram_addr;
    logic [FC_W-1:0]   frame_sel;
    logic [WD_W-1:0]   word_sel;
    logic [FC_W-1:0]   efc;
    logic [WD_W-1:0]   ewi;
    logic [FC_W-1:0]   ccf;
    logic              emit_now;

    function automatic logic [HF_W-1:0] wrap_frame(input logic [FC_W:0] v);
        logic [FC_W:0] lim;
        lim = (FC_W + 1)'(MAX_FRAMES);
        if (v >= lim) begin
            return HF_W'(v - lim);
        end
        return HF_W'(v);
    endfunction

    assign op      = t_opcode'(i_s_axis_tuser);
    assign a_move  = r_a_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || a_move;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign size   = (SIZE_W'(r_dc) - SIZE_W'(1)) * SIZE_W'(r_ss) + SIZE_W'(r_rl);
    assign stride = SIZE_W'(r_ss) * SIZE_W'(r_dc);

    assign cfg_bad = (r_ss == '0) || (SIZE_W'(r_ss) > SS_MAX)
                  || (r_dc == '0) || (SIZE_W'(r_dc) > DC_MAX)
                  || (r_rl == '0) || (SIZE_W'(r_rl) > RL_MAX)
                  || (r_fd == '0) || (SIZE_W'(r_fd) > FD_MAX)
                  || (SIZE_W'(r_fd) > MAX_DIM_C)
                  || (size > MAX_FRAMES_C);

    assign ram_addr = ADDR_W'(wrap_frame((FC_W + 1)'(r_head) + (FC_W + 1)'(frame_sel)))
                      * DIM_ADDR + ADDR_W'(word_sel);

    always_comb begin
        n_head     = r_head;
        n_fh       = r_fh;
        n_wwi      = r_wwi;
        n_efc      = r_efc;
        n_ewi      = r_ewi;
        n_ccf      = r_ccf;
        n_ended    = r_ended;
        n_emitting = r_emitting;
        n_a_wvalid = 1'b0;
        n_a_pad    = 1'b0;
        n_a_last   = 1'b0;
        n_a_status = ST_OK;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = i_s_axis_tdata;
        frame_sel  = r_fh;
        word_sel   = r_wwi;
        efc        = r_efc;
        ewi        = r_ewi;
        ccf        = r_ccf;
        emit_now   = r_emitting;
        keep       = '0;
        if (accept) begin
            if (op == OP_CLEAR) begin
                n_head     = '0;
                n_fh       = '0;
                n_wwi      = '0;
                n_efc      = '0;
                n_ewi      = '0;
                n_ccf      = '0;
                n_ended    = 1'b0;
                n_emitting = 1'b0;
            end else if (cfg_bad) begin
                n_a_status = ST_CFG_ERR;
            end else begin
                case (op)
                    OP_EOS: begin
                        n_ended = 1'b1;
                        n_wwi   = '0;
                    end
                    OP_PUSH: begin
                        if (r_emitting) begin
                            n_a_status = ST_BUSY;
                        end else if (SIZE_W'(r_fh) >= size) begin
                            n_a_status = ST_FULL;
                        end else begin
                            ram_we = 1'b1;
                            if (SIZE_W'(r_wwi) + SIZE_W'(1) >= SIZE_W'(r_fd)) begin
                                n_wwi = '0;
                                n_fh  = r_fh + FC_W'(1);
                            end else begin
                                n_wwi = r_wwi + WD_W'(1);
                            end
                        end
                    end
                    OP_PULL: begin
                        if (!r_emitting) begin
                            if ((SIZE_W'(r_fh) >= size)
                                    || (r_ended && SIZE_W'(r_fh) >= SIZE_W'(r_rl))) begin
                                if (r_zf || SIZE_W'(r_fh) >= size) begin
                                    ccf = FC_W'(size);
                                end else begin
                                    ccf = r_fh;
                                end
                                efc        = '0;
                                ewi        = '0;
                                n_wwi      = '0;
                                emit_now   = 1'b1;
                                n_ccf      = ccf;
                                n_efc      = '0;
                                n_ewi      = '0;
                                n_emitting = 1'b1;
                            end else begin
                                n_a_status = ST_NOT_READY;
                            end
                        end
                        if (emit_now) begin
                            frame_sel  = efc;
                            word_sel   = ewi;
                            n_a_wvalid = 1'b1;
                            n_a_pad    = (efc >= r_fh);
                            ram_we     = n_a_pad;
                            ram_re     = !n_a_pad;
                            ram_wdata  = '0;
                            if (SIZE_W'(ewi) + SIZE_W'(1) >= SIZE_W'(r_fd)) begin
                                n_ewi = '0;
                                if (SIZE_W'(efc) + SIZE_W'(1) >= SIZE_W'(ccf)) begin
                                    if (size > stride) begin
                                        keep = size - stride;
                                    end
                                    if (keep > SIZE_W'(ccf)) begin
                                        keep = SIZE_W'(ccf);
                                    end
                                    n_head = wrap_frame((FC_W + 1)'(r_head)
                                                        + (FC_W + 1)'(ccf)
                                                        - (FC_W + 1)'(keep));
                                    n_fh       = FC_W'(keep);
                                    n_efc      = '0;
                                    n_ccf      = '0;
                                    n_emitting = 1'b0;
                                    n_a_last   = 1'b1;
                                end else begin
                                    n_efc = efc + FC_W'(1);
                                end
                            end else begin
                                n_ewi = ewi + WD_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    ofc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= SS_RESET;
            r_dc <= DC_RESET;
            r_rl <= RL_RESET;
            r_zf <= ZF_RESET;
            r_fd <= FD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SUBSAMPLING: r_ss <= i_cfg_wdata[SS_W-1:0];
                CFG_DEC_CHUNK:   r_dc <= i_cfg_wdata[DC_W-1:0];
                CFG_RECEPTIVE:   r_rl <= i_cfg_wdata[RL_W-1:0];
                CFG_ZERO_FILL:   r_zf <= i_cfg_wdata[0];
                CFG_FRAME_DIM:   r_fd <= i_cfg_wdata[FD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_fh       <= '0;
            r_wwi      <= '0;
            r_efc      <= '0;
            r_ewi      <= '0;
            r_ccf      <= '0;
            r_ended    <= 1'b0;
            r_emitting <= 1'b0;
            r_a_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_fh       <= n_fh;
            r_wwi      <= n_wwi;
            r_efc      <= n_efc;
            r_ewi      <= n_ewi;
            r_ccf      <= n_ccf;
            r_ended    <= n_ended;
            r_emitting <= n_emitting;
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_wvalid <= n_a_wvalid;
            r_a_pad    <= n_a_pad;
            r_a_last   <= n_a_last;
            r_a_status <= n_a_status;
        end
        if (a_move) begin
            r_o_word   <= (r_a_wvalid && !r_a_pad) ? ram_rdata : '0;
            r_o_wvalid <= r_a_wvalid;
            r_o_last   <= r_a_last;
            r_o_status <= r_a_status;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_word;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = {r_o_status, r_o_wvalid};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> (r_efc < r_ccf))
        else $error("Emitted frame count has run past the chunk length.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_emitting |-> (r_ccf == '0))
        else $error("Chunk length left set outside a chunk.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SIZE_W'(r_fh) <= MAX_FRAMES_C)
        else $error("Frame store holds more frames than it has room for.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser[0])
        else $error("End of chunk flagged on a transaction without a word.");

endmodule

`default_nettype wire

>>> dv/overlapping_frame_chunker_tb.sv
// ----------------------------------------------------------------------------
// overlapping_frame_chunker_tb
// Self-checking testbench for the overlapping frame chunker.
// ----------------------------------------------------------------------------
// A directed table covers reset behaviour, full and busy refusals, end of
// stream, zero padding, partial frames and bad configurations. It is followed
// by random phases, each with its own register setting, in which pushes and
// pulls mostly follow the fill-then-drain pattern of real use. Every result
// transaction is checked against its table row's value, if given, or an
// in-bench model of the frame store and chunk counters. Both stream sides idle
// at random, and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module overlapping_frame_chunker_tb
    import ofc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_FRAMES = MAX_FRAMES_DEF;
    localparam int STORE_DIM    = MAX_DIM_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_PHASE   = 10;
    localparam int NUM_PHASES   = 14;
    localparam int MAX_REPORTS  = 30;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              valid;
        logic              last;
        t_status           status;
    } t_chunk_result;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_opcode              op;
        logic [WORD_W-1:0]    data;
        bit                   typed;
        t_chunk_result        want;
    } t_stim_row;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [WORD_W-1:0]    s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = OP_PUSH;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic [STATUS_W:0]    m_tuser;

    // Model of the block: frame store, counters and register copies.
    logic [WORD_W-1:0] shadow_store [STORE_FRAMES*STORE_DIM];
    int head_slot, held_frames, fill_word, out_frame, out_word, chunk_frames;
    bit eos_seen, draining;
    int ss_cfg, dc_cfg, rl_cfg, zf_cfg, fd_cfg;

    t_chunk_result expected_results[$];

    int error_count   = 0;
    int checked_count = 0;
    int chunk_count   = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int status_hist [5] = '{0, 0, 0, 0, 0};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_started  = 0;
    int hold_left      = 0;

    overlapping_frame_chunker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit cfg_legal(int ss, int dc, int rl, int fd);
        if (ss < 1 || ss > 8 || dc < 1 || dc > 16 || rl < 1 || rl > 64) return 1'b0;
        if (fd < 1 || fd > STORE_DIM) return 1'b0;
        return (dc - 1) * ss + rl <= STORE_FRAMES;
    endfunction

    function automatic int chunk_len();
        return (dc_cfg - 1) * ss_cfg + rl_cfg;
    endfunction

    function automatic int slot(int frame, int word);
        return ((head_slot + frame) % STORE_FRAMES) * STORE_DIM + (word % STORE_DIM);
    endfunction

    function automatic void clear_chunker();
        head_slot = 0; held_frames = 0; fill_word = 0;
        out_frame = 0; out_word = 0; chunk_frames = 0;
        eos_seen = 1'b0; draining = 1'b0;
    endfunction

    function automatic t_chunk_result advance_chunker(t_opcode op, logic [WORD_W-1:0] w);
        t_chunk_result r;
        int size, stride, keep, n, s;
        bit ready;
        r = '{word: '0, valid: 1'b0, last: 1'b0, status: ST_OK};
        size = chunk_len();
        if (op == OP_CLEAR) begin
            clear_chunker();
        end else if (!cfg_legal(ss_cfg, dc_cfg, rl_cfg, fd_cfg)) begin
            r.status = ST_CFG_ERR;
        end else if (op == OP_EOS) begin
            eos_seen = 1'b1;
            fill_word = 0;
        end else if (op == OP_PUSH) begin
            if (draining) begin
                r.status = ST_BUSY;
            end else if (held_frames >= size) begin
                r.status = ST_FULL;
            end else begin
                shadow_store[slot(held_frames, fill_word)] = w;
                fill_word++;
                if (fill_word >= fd_cfg) begin
                    fill_word = 0;
                    held_frames++;
                end
            end
        end else begin
            if (!draining) begin
                ready = held_frames >= size || (eos_seen && held_frames >= rl_cfg);
                if (ready) begin
                    n = (held_frames < size) ? held_frames : size;
                    if (zf_cfg != 0) n = size;
                    chunk_frames = n;
                    out_frame = 0;
                    out_word = 0;
                    fill_word = 0;
                    draining = 1'b1;
                end else begin
                    r.status = ST_NOT_READY;
                end
            end
            if (draining) begin
                s = slot(out_frame, out_word);
                if (out_frame >= held_frames) shadow_store[s] = '0;
                r.word = shadow_store[s];
                r.valid = 1'b1;
                out_word++;
                if (out_word >= fd_cfg) begin
                    out_word = 0;
                    out_frame++;
                    if (out_frame >= chunk_frames) begin
                        stride = ss_cfg * dc_cfg;
                        keep = (size > stride) ? size - stride : 0;
                        if (keep > chunk_frames) keep = chunk_frames;
                        head_slot = (head_slot + chunk_frames - keep) % STORE_FRAMES;
                        held_frames = keep;
                        out_frame = 0;
                        chunk_frames = 0;
                        draining = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Mostly fill-then-drain traffic, with some refused and out-of-order requests.
    function automatic t_opcode pick_op();
        int r;
        r = $urandom_range(99);
        if (!cfg_legal(ss_cfg, dc_cfg, rl_cfg, fd_cfg))
            return r < 40 ? OP_PUSH : r < 70 ? OP_PULL : r < 85 ? OP_EOS : OP_CLEAR;
        if (draining)
            return r < 90 ? OP_PULL : r < 95 ? OP_PUSH : r < 99 ? OP_EOS : OP_CLEAR;
        if (held_frames >= chunk_len() || (eos_seen && held_frames >= rl_cfg))
            return r < 80 ? OP_PULL : r < 95 ? OP_PUSH : r < 98 ? OP_EOS : OP_CLEAR;
        return r < 90 ? OP_PUSH : r < 96 ? OP_PULL : r < 98 ? OP_EOS : OP_CLEAR;
    endfunction

    function automatic t_stim_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_stim_row row;
        row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, op: OP_PUSH, data: '0,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row op_row(t_opcode op, logic [WORD_W-1:0] data);
        t_stim_row row;
        row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, op: op, data: data,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_stim_row op_row_exp(t_opcode op, logic [WORD_W-1:0] data,
                                             logic [WORD_W-1:0] w, logic v, logic l,
                                             t_status st);
        t_stim_row row;
        row = op_row(op, data);
        row.typed = 1'b1;
        row.want = '{word: w, valid: v, last: l, status: st};
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
    endtask

    task automatic send_item(input t_opcode op, input logic [WORD_W-1:0] w, input bit typed,
                             input t_chunk_result want);
        t_chunk_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        predicted = advance_chunker(op, w);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SUBSAMPLING: ss_cfg = int'(val[SS_W-1:0]);
            CFG_DEC_CHUNK:   dc_cfg = int'(val[DC_W-1:0]);
            CFG_RECEPTIVE:   rl_cfg = int'(val[RL_W-1:0]);
            CFG_ZERO_FILL:   zf_cfg = int'(val[0]);
            CFG_FRAME_DIM:   fd_cfg = int'(val[FD_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (holds_asked != holds_started) begin
            holds_started = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_chunk_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.word   = m_tdata;
            got.valid  = m_tuser[0];
            got.last   = m_tlast;
            got.status = t_status'(m_tuser[STATUS_W:1]);
            checked_count++;
            if (got.last === 1'b1) chunk_count++;
            if (got.status inside {ST_OK, ST_NOT_READY, ST_FULL, ST_BUSY, ST_CFG_ERR})
                status_hist[int'(got.status)]++;
            if (expected_results.size() == 0) begin
                report_mismatch("result transaction with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got word %h valid %b last %b status %0d, expected %h %b %b %0d",
                        got.word, got.valid, got.last, got.status,
                        want.word, want.valid, want.last, want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached with %0d results outstanding",
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_stim_row dir_table[$];
        int p, k, n_items, dim_floor;
        int ss, dc, rl, zf, fd;
        bit good;

        dir_table = '{
            op_row_exp(OP_PULL,  32'h0000_0000, '0, 1'b0, 1'b0, ST_NOT_READY),
            op_row_exp(OP_PUSH,  32'hFFFF_FFFF, '0, 1'b0, 1'b0, ST_OK),
            op_row_exp(OP_EOS,   32'hFFFF_FFFF, '0, 1'b0, 1'b0, ST_OK),
            op_row_exp(OP_CLEAR, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, ST_OK),
            reg_row(CFG_FRAME_DIM, 8'd1),
            reg_row(CFG_SUBSAMPLING, 8'd1),
            reg_row(CFG_RECEPTIVE, 8'd2),
            op_row_exp(OP_PUSH,  32'hFFFF_FFFF, '0, 1'b0, 1'b0, ST_OK),
            op_row_exp(OP_PUSH,  32'h0000_0000, '0, 1'b0, 1'b0, ST_OK),
            op_row_exp(OP_PUSH,  32'h1234_5678, '0, 1'b0, 1'b0, ST_FULL),
            op_row_exp(OP_PULL,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK),
            op_row_exp(OP_PUSH,  32'h8765_4321, '0, 1'b0, 1'b0, ST_BUSY),
            op_row_exp(OP_PULL,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, ST_OK),
            reg_row(CFG_DEC_CHUNK, 8'd3),
            reg_row(CFG_ZERO_FILL, 8'd1),
            op_row(OP_EOS,  32'h0000_0000),
            op_row(OP_PUSH, 32'hA5A5_A5A5),
            op_row(OP_PULL, 32'h0000_0000),
            op_row(OP_PULL, 32'h0000_0000),
            op_row(OP_PULL, 32'h0000_0000),
            op_row(OP_PULL, 32'h0000_0000),
            reg_row(CFG_SUBSAMPLING, 8'd0),
            op_row_exp(OP_PUSH,  32'h5555_5555, '0, 1'b0, 1'b0, ST_CFG_ERR),
            op_row_exp(OP_CLEAR, 32'h0000_0000, '0, 1'b0, 1'b0, ST_OK),
            reg_row(CFG_SUBSAMPLING, 8'd8),
            reg_row(CFG_DEC_CHUNK, 8'd16),
            op_row_exp(OP_EOS,   32'h0000_0000, '0, 1'b0, 1'b0, ST_CFG_ERR),
            reg_row(CFG_SUBSAMPLING, 8'd1),
            reg_row(CFG_DEC_CHUNK, 8'd1),
            reg_row(CFG_RECEPTIVE, 8'd1),
            reg_row(CFG_ZERO_FILL, 8'd0),
            reg_row(CFG_SPARE, 8'hFF),
            reg_row(CFG_FRAME_DIM, 8'd2),
            op_row(OP_PUSH, 32'h0000_0001),
            op_row(OP_EOS,  32'h0000_0000),
            op_row(OP_PUSH, 32'hC3C3_C3C3),
            op_row(OP_PUSH, 32'h3C3C_3C3C),
            op_row(OP_PULL, 32'h0000_0000),
            op_row(OP_PULL, 32'h0000_0000)
        };

        clear_chunker();
        ss_cfg = int'(SS_RESET);
        dc_cfg = int'(DC_RESET);
        rl_cfg = int'(RL_RESET);
        zf_cfg = int'(ZF_RESET);
        fd_cfg = int'(FD_RESET);
        send_idle_pct  = 25;
        recv_stall_pct = 61;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) begin
            if (dir_table[k].is_reg) begin
                wait_idle();
                write_reg(dir_table[k].reg_idx, dir_table[k].reg_val);
                cfg_we <= 1'b0;
            end else begin
                send_item(dir_table[k].op, dir_table[k].data, dir_table[k].typed,
                          dir_table[k].want);
            end
        end

        dim_floor = fd_cfg;
        for (p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = (p < 5) ? 25 : (p < 10) ? 61 : 0;
            recv_stall_pct = (p < 5) ? 61 : (p < 10) ? 25 : 0;
            n_items = 140;
            case (p)
                0: begin ss = 1; dc = 1;  rl = 1;   zf = 0; fd = 1; end
                1: begin ss = 8; dc = 1;  rl = 64;  zf = 1; fd = 1; end
                2: begin ss = 4; dc = 16; rl = 4;   zf = 0; fd = 1; end
                3: begin ss = 15; dc = 31; rl = 127; zf = 1; fd = 255; n_items = 40; end
                4: begin ss = 1; dc = 1;  rl = 1;   zf = 1; fd = 128; n_items = 300; end
                7: begin ss = 0; dc = 0;  rl = 0;   zf = 0; fd = 0; n_items = 40; end
                default: begin
                    zf = $urandom_range(0, 1);
                    if ($urandom_range(3) == 0) begin
                        ss = $urandom_range(1, 8);
                        dc = $urandom_range(1, (1 + 63 / ss) > 16 ? 16 : 1 + 63 / ss);
                        rl = $urandom_range(1, 64 - (dc - 1) * ss);
                        fd = 1;
                    end else begin
                        ss = $urandom_range(1, 4);
                        dc = $urandom_range(1, 4);
                        rl = $urandom_range(1, 8);
                        fd = $urandom_range(1, 3);
                    end
                end
            endcase

            wait_idle();
            write_reg(CFG_SUBSAMPLING, CFG_W'(ss));
            write_reg(CFG_DEC_CHUNK, CFG_W'(dc));
            write_reg(CFG_RECEPTIVE, CFG_W'(rl));
            write_reg(CFG_ZERO_FILL, CFG_W'(zf));
            write_reg(CFG_FRAME_DIM, CFG_W'(fd));
            cfg_we <= 1'b0;

            // Stored frames hold only as many words as the narrowest setting
            // since the last clear, so a wider frame needs an empty store.
            good = cfg_legal(ss, dc, rl, fd);
            if (good && fd > dim_floor) send_item(OP_CLEAR, $urandom(), 1'b0, '0);
            if (good) dim_floor = fd;
            if (p == HOLD_PHASE) holds_asked++;

            for (k = 0; k < n_items; k++) send_item(pick_op(), $urandom(), 1'b0, '0);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d transactions over %0d register settings,",
                 items_sent, NUM_PHASES + 1);
        $display("with one %0d-cycle output hold-off; checked %0d results, %0d chunks.",
                 HOLD_CYCLES, checked_count, chunk_count);
        $display("Refusals: %0d not ready, %0d full, %0d busy, %0d bad config.",
                 status_hist[1], status_hist[2], status_hist[3], status_hist[4]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/ofc_pkg.sv
hw/rtl/ofc_ram.sv
hw/rtl/overlapping_frame_chunker.sv
dv/overlapping_frame_chunker_tb.sv
